>>> rtl/lzsd_pkg.sv
// Shared types, codes and constants of the LZSS bitstream decoder.
// No dependencies; the bit accumulator, the top level and the bench refer to it by scoped names.
`default_nettype none

package lzsd_pkg;

  localparam int MAX_DIST_BITS_DEF = 12;
  localparam int MAX_LEN_BITS_DEF  = 5;

  // bits that one parse step can take (distance field up to 15 bits)
  localparam int FIELD_N_W = 5;
  // bit accumulator: a new word is dropped once more than ACC_LIMIT bits are held
  localparam int ACC_W     = 64;
  localparam int ACC_LIMIT = 56;
  localparam int HELD_W    = 7;

  localparam int MAX_RESULTS = 32;
  localparam int LIT_BITS    = 8;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_DIST  = 2'd0;
  localparam logic [1:0] CFG_LEN   = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  localparam logic [3:0] CFG_DIST_RST  = 4'd12;
  localparam logic [2:0] CFG_LEN_RST   = 3'd4;
  localparam logic [3:0] CFG_COUNT_RST = 4'd8;

  // result kinds
  localparam logic [1:0] KIND_BYTE     = 2'd0;
  localparam logic [1:0] KIND_END      = 2'd1;
  localparam logic [1:0] KIND_BAD_DIST = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARSE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_DIST,
    PH_COUNT,
    PH_LIT
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic                 append;
    logic [7:0]           byte_in;
    logic                 take;
    logic [FIELD_N_W-1:0] take_n;
  } acc_ctl_t;

endpackage

`default_nettype wire

>>> rtl/lzsd_channels.sv
// Valid/ready channel interfaces of the decoder: compressed input and results.
// Depends on nothing.
`default_nettype none

interface lzsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface lzsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output kind, output out_byte, output run_last, input ready);
  modport sink   (input valid, input kind, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

>>> rtl/lzsd_hist_ram.sv
// History memory of the decoder: one write port, one registered read port.
// Depends on nothing.
`default_nettype none

module lzsd_hist_ram #(
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [7:0]        wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [7:0]        rd_data
);

  logic [7:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lzsd_bit_accum.sv
// Bit accumulator: appends input words above the held bits, hands out fields LSB first.
// Depends on lzsd_pkg (acc_ctl_t, accumulator sizes).
`default_nettype none

module lzsd_bit_accum #(
  parameter int FW = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire lzsd_pkg::acc_ctl_t        ctl,
  output logic      [FW-1:0]             peek,
  output logic      [lzsd_pkg::HELD_W-1:0] held
);

  localparam int AW = lzsd_pkg::ACC_W;
  localparam int HW = lzsd_pkg::HELD_W;

  logic [AW-1:0] acc_r, acc_nxt;
  logic [HW-1:0] held_r, held_nxt;

  always_comb begin
    acc_nxt  = acc_r;
    held_nxt = held_r;
    if (ctl.append) begin
      if (held_r <= HW'(lzsd_pkg::ACC_LIMIT)) begin
        acc_nxt  = acc_r | (AW'(ctl.byte_in) << held_r);
        held_nxt = held_r + HW'(8);
      end
    end else if (ctl.take) begin
      acc_nxt  = acc_r >> ctl.take_n;
      held_nxt = held_r - HW'(ctl.take_n);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      held_r <= '0;
    end else begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
    end
  end

  assign peek = acc_r[FW-1:0];
  assign held = held_r;

endmodule

`default_nettype wire

>>> rtl/lzss_bitstream_decoder.sv
// LZSS bitstream decoder, top level: parse sequencer, result buffer, config registers.
// Depends on lzsd_pkg, lzsd_channels, lzsd_hist_ram and lzsd_bit_accum.
//
// Usage: compressed bytes enter on in_ch, one word per handshake, bits taken LSB first.
// Each input word yields zero to 32 results on out_ch (kind, out_byte, run_last);
// run_last marks the last result caused by that word. A bad distance or an end
// marker yields one final result, after which input words are taken and dropped.
// cfg_we/cfg_idx/cfg_data write dist_bits, len_bits, count_bits; the user must do so only
// while idle, the block itself does not enforce it. For each input word the sequencer
// accepts it, parses fields and literals, copies each byte as a history read then a
// write-back, finds that nothing more can be parsed and releases the last result, if any.
// Results pass through a one-entry hold buffer (to learn run_last) and an output
// register; a stalled receiver stops the sequencer, never drops or repeats a word.
// in_ch.ready is high whenever the sequencer waits for input, even while a
// result sits unread in the output register.
// Reset (synchronous, rst_n low) empties the parser and output, restores the
// register defaults and marks the history empty; no clearing pass is needed.
`default_nettype none

module lzss_bitstream_decoder #(
  parameter int MAX_DIST_BITS = lzsd_pkg::MAX_DIST_BITS_DEF,
  parameter int MAX_LEN_BITS  = lzsd_pkg::MAX_LEN_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  lzsd_in_if.sink         in_ch,
  lzsd_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [3:0] cfg_data
);

  localparam int FW     = (MAX_DIST_BITS > 8) ? MAX_DIST_BITS : 8;
  localparam int FILL_W = MAX_DIST_BITS + 1;
  localparam int CL_W   = MAX_LEN_BITS + 1;
  localparam int NW     = lzsd_pkg::FIELD_N_W;
  localparam int HW     = lzsd_pkg::HELD_W;
  localparam logic [FILL_W-1:0] HIST_FULL = {1'b1, {MAX_DIST_BITS{1'b0}}};

  // configuration registers
  logic [3:0] cfg_dist_r;
  logic [2:0] cfg_len_r;
  logic [3:0] cfg_count_r;

  lzsd_pkg::state_t state_r, state_nxt;
  lzsd_pkg::phase_t phase_r, phase_nxt;
  logic [MAX_LEN_BITS-1:0]  pl_r, pl_nxt;
  logic [7:0]               lit_r, lit_nxt;
  logic [MAX_DIST_BITS-1:0] dist_r, dist_nxt;
  logic [CL_W-1:0]          copy_left_r, copy_left_nxt;
  logic [MAX_DIST_BITS-1:0] wp_r, wp_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  logic                     stopped_r, stopped_nxt;
  logic [5:0]               n_r, n_nxt;
  logic                     pend_v_r, pend_v_nxt;
  lzsd_pkg::res_t           pend_r, pend_nxt;
  logic                     out_v_r, out_v_nxt;
  lzsd_pkg::res_t           out_r, out_nxt;

  lzsd_pkg::acc_ctl_t acc_ctl;
  logic [FW-1:0]      peek;
  logic [HW-1:0]      held;

  logic                     mem_we, mem_re;
  logic [7:0]               mem_wdata, mem_rdata;
  logic [MAX_DIST_BITS-1:0] mem_raddr;

  logic [NW-1:0] d_eff, l_eff, c_eff, need_n;
  logic [FW-1:0] field;
  logic [FILL_W-1:0] win, lim;
  logic have, room, bad_dist, can_push, gen_ok, end_loop;
  logic res_fire, flush_fire;
  lzsd_pkg::res_t res_val;

  lzsd_bit_accum #(.FW(FW)) u_accum (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (acc_ctl),
    .peek (peek),
    .held (held)
  );

  lzsd_hist_ram #(.ADDR_W(MAX_DIST_BITS)) u_hist (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(wp_r),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  // clamped field widths
  always_comb begin
    d_eff = {1'b0, cfg_dist_r};
    if (d_eff < NW'(2)) d_eff = NW'(2);
    if (d_eff > NW'(MAX_DIST_BITS)) d_eff = NW'(MAX_DIST_BITS);
    l_eff = {2'b00, cfg_len_r};
    if (l_eff < NW'(1)) l_eff = NW'(1);
    if (l_eff > NW'(MAX_LEN_BITS)) l_eff = NW'(MAX_LEN_BITS);
    if (l_eff >= d_eff) l_eff = d_eff - NW'(1);
    c_eff = {1'b0, cfg_count_r};
    if (c_eff < NW'(1)) c_eff = NW'(1);
    if (c_eff > NW'(8)) c_eff = NW'(8);
  end

  always_comb begin
    case (phase_r)
      lzsd_pkg::PH_LEN:   need_n = l_eff;
      lzsd_pkg::PH_DIST:  need_n = d_eff;
      lzsd_pkg::PH_COUNT: need_n = c_eff;
      default:            need_n = NW'(lzsd_pkg::LIT_BITS);
    endcase
  end

  assign field = peek & ~({FW{1'b1}} << need_n);
  assign have  = held >= {2'b00, need_n};

  always_comb begin
    case (phase_r)
      lzsd_pkg::PH_LEN:  room = 1'b1;
      lzsd_pkg::PH_DIST: room = ({1'b0, n_r} + 7'(pl_r) + 7'd1) <= 7'(lzsd_pkg::MAX_RESULTS);
      default:           room = n_r < 6'(lzsd_pkg::MAX_RESULTS);
    endcase
  end

  // usable window is the filled part, capped at 2^D - 2^L
  assign win      = (FILL_W'(1) << d_eff) - (FILL_W'(1) << l_eff);
  assign lim      = (fill_r < win) ? fill_r : win;
  assign bad_dist = (field[MAX_DIST_BITS-1:0] == '0) ||
                    ({1'b0, field[MAX_DIST_BITS-1:0]} > lim);

  assign can_push = !out_v_r || out_ch.ready;
  assign gen_ok   = !pend_v_r || can_push;
  assign end_loop = !have || !room;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pl_nxt        = pl_r;
    lit_nxt       = lit_r;
    dist_nxt      = dist_r;
    copy_left_nxt = copy_left_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    stopped_nxt   = stopped_r;
    n_nxt         = n_r;
    acc_ctl       = '0;
    mem_we        = 1'b0;
    mem_wdata     = field[7:0];
    mem_re        = 1'b0;
    mem_raddr     = wp_r - dist_r;
    res_fire      = 1'b0;
    res_val       = '0;
    flush_fire    = 1'b0;
    in_ch.ready   = 1'b0;
    acc_ctl.take_n  = need_n;
    acc_ctl.byte_in = in_ch.in_byte;

    case (state_r)
      lzsd_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && !stopped_r) begin
          acc_ctl.append = 1'b1;
          n_nxt          = '0;
          state_nxt      = lzsd_pkg::ST_PARSE;
        end
      end
      lzsd_pkg::ST_PARSE: begin
        if (end_loop) begin
          state_nxt = pend_v_r ? lzsd_pkg::ST_FLUSH : lzsd_pkg::ST_IDLE;
        end else begin
          case (phase_r)
            lzsd_pkg::PH_LEN: begin
              acc_ctl.take = 1'b1;
              if (field[MAX_LEN_BITS-1:0] != '0) begin
                pl_nxt    = field[MAX_LEN_BITS-1:0];
                phase_nxt = lzsd_pkg::PH_DIST;
              end else begin
                phase_nxt = lzsd_pkg::PH_COUNT;
              end
            end
            lzsd_pkg::PH_DIST: begin
              if (bad_dist) begin
                if (gen_ok) begin
                  acc_ctl.take = 1'b1;
                  res_fire     = 1'b1;
                  res_val.kind = lzsd_pkg::KIND_BAD_DIST;
                  stopped_nxt  = 1'b1;
                  state_nxt    = lzsd_pkg::ST_FLUSH;
                end
              end else begin
                acc_ctl.take  = 1'b1;
                dist_nxt      = field[MAX_DIST_BITS-1:0];
                copy_left_nxt = {1'b0, pl_r} + CL_W'(1);
                phase_nxt     = lzsd_pkg::PH_LEN;
                state_nxt     = lzsd_pkg::ST_COPY_RD;
              end
            end
            lzsd_pkg::PH_COUNT: begin
              if (field[7:0] == 8'd0) begin
                if (gen_ok) begin
                  acc_ctl.take = 1'b1;
                  res_fire     = 1'b1;
                  res_val.kind = lzsd_pkg::KIND_END;
                  stopped_nxt  = 1'b1;
                  state_nxt    = lzsd_pkg::ST_FLUSH;
                end
              end else begin
                acc_ctl.take = 1'b1;
                lit_nxt      = field[7:0];
                phase_nxt    = lzsd_pkg::PH_LIT;
              end
            end
            default: begin
              if (gen_ok) begin
                acc_ctl.take     = 1'b1;
                res_fire         = 1'b1;
                res_val.kind     = lzsd_pkg::KIND_BYTE;
                res_val.out_byte = field[7:0];
                mem_we           = 1'b1;
                wp_nxt           = wp_r + MAX_DIST_BITS'(1);
                if (fill_r != HIST_FULL) fill_nxt = fill_r + FILL_W'(1);
                n_nxt            = n_r + 6'd1;
                if (lit_r != 8'd0) lit_nxt = lit_r - 8'd1;
                if (lit_r <= 8'd1) phase_nxt = lzsd_pkg::PH_LEN;
              end
            end
          endcase
        end
      end
      lzsd_pkg::ST_COPY_RD: begin
        mem_re    = 1'b1;
        state_nxt = lzsd_pkg::ST_COPY_WR;
      end
      lzsd_pkg::ST_COPY_WR: begin
        // rd_data holds across a stall since no new read is issued
        if (gen_ok) begin
          res_fire         = 1'b1;
          res_val.kind     = lzsd_pkg::KIND_BYTE;
          res_val.out_byte = mem_rdata;
          mem_we           = 1'b1;
          mem_wdata        = mem_rdata;
          wp_nxt           = wp_r + MAX_DIST_BITS'(1);
          if (fill_r != HIST_FULL) fill_nxt = fill_r + FILL_W'(1);
          n_nxt            = n_r + 6'd1;
          copy_left_nxt    = copy_left_r - CL_W'(1);
          state_nxt        = (copy_left_r == CL_W'(1)) ? lzsd_pkg::ST_PARSE
                                                       : lzsd_pkg::ST_COPY_RD;
        end
      end
      lzsd_pkg::ST_FLUSH: begin
        if (can_push) begin
          flush_fire = 1'b1;
          state_nxt  = lzsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lzsd_pkg::ST_IDLE;
      end
    endcase
  end

  // hold buffer: a word moves on only once the next one (or the end of the step) is known
  always_comb begin
    out_v_nxt  = out_v_r && !out_ch.ready;
    out_nxt    = out_r;
    pend_v_nxt = pend_v_r;
    pend_nxt   = pend_r;
    if (res_fire) begin
      if (pend_v_r) begin
        out_v_nxt        = 1'b1;
        out_nxt          = pend_r;
        out_nxt.run_last = 1'b0;
      end
      pend_nxt   = res_val;
      pend_v_nxt = 1'b1;
    end
    if (flush_fire) begin
      out_v_nxt        = 1'b1;
      out_nxt          = pend_r;
      out_nxt.run_last = 1'b1;
      pend_v_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_dist_r  <= lzsd_pkg::CFG_DIST_RST;
      cfg_len_r   <= lzsd_pkg::CFG_LEN_RST;
      cfg_count_r <= lzsd_pkg::CFG_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        lzsd_pkg::CFG_DIST:  cfg_dist_r  <= cfg_data;
        lzsd_pkg::CFG_LEN:   cfg_len_r   <= cfg_data[2:0];
        lzsd_pkg::CFG_COUNT: cfg_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lzsd_pkg::ST_IDLE;
      phase_r     <= lzsd_pkg::PH_LEN;
      pl_r        <= '0;
      lit_r       <= '0;
      copy_left_r <= '0;
      wp_r        <= '0;
      fill_r      <= '0;
      stopped_r   <= 1'b0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pl_r        <= pl_nxt;
      lit_r       <= lit_nxt;
      copy_left_r <= copy_left_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      stopped_r   <= stopped_nxt;
      n_r         <= n_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.kind     = out_r.kind;
  assign out_ch.out_byte = out_r.out_byte;
  assign out_ch.run_last = out_r.run_last;

`ifndef SYNTHESIS
  // the held result is always released before the next input word
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzsd_pkg::ST_IDLE) |-> !pend_v_r)
    else $error("result left in hold buffer at idle");

  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lzsd_pkg::ST_COPY_RD || state_r == lzsd_pkg::ST_COPY_WR) |->
      (copy_left_r != '0))
    else $error("copy running with no bytes left");

  a_dist_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lzsd_pkg::PH_DIST) |-> (pl_r != '0))
    else $error("distance phase without a copy length");

  a_stop_flush: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stopped_r) |-> (state_r == lzsd_pkg::ST_FLUSH && pend_v_r))
    else $error("stop without a final result");
`endif

endmodule

`default_nettype wire

>>> bench/tb_lzss_bitstream_decoder.sv
// Self-checking bench for lzss_bitstream_decoder: builds a compressed stream
// phase by phase, predicts every result word and checks it against the out_ch channel.
// Depends on lzsd_pkg, lzsd_channels and the decoder RTL.
module tb_lzss_bitstream_decoder;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 100;
  localparam int HIST_DEPTH  = 1 << lzsd_pkg::MAX_DIST_BITS_DEF;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_idx;
  logic [3:0] cfg_data;

  lzsd_in_if  in_ch ();
  lzsd_out_if out_ch ();

  lzss_bitstream_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // decoder state as the bench sees it
  logic [63:0]       acc;
  int unsigned       held;
  lzsd_pkg::phase_t  ph;
  int unsigned       pend_len;
  int unsigned       lits_left;
  logic [7:0]        hist [0:HIST_DEPTH-1];
  logic [11:0]       wp;
  int unsigned       fill;
  bit                halted;
  logic [3:0]        reg_dist;
  logic [2:0]        reg_len;
  logic [3:0]        reg_count;

  lzsd_pkg::res_t    expected_q [$];
  lzsd_pkg::res_t    last_res;
  bit                have_res;
  int unsigned       step_n;

  // stream builder
  logic [7:0]   word_q [$];
  logic [7:0]   wbuf;
  int unsigned  wcnt;
  int unsigned  words_made;
  int unsigned  gen_out;
  int unsigned  gd, gl, gc, gen_win;

  bit           calm;
  int unsigned  errors;
  int unsigned  words_in;
  int unsigned  results_seen;
  int unsigned  settings_used;
  int unsigned  cycles;
  string        stop_note;

  function automatic int unsigned width_dist();
    int unsigned d;
    d = reg_dist;
    if (d < 2) d = 2;
    if (d > lzsd_pkg::MAX_DIST_BITS_DEF) d = lzsd_pkg::MAX_DIST_BITS_DEF;
    return d;
  endfunction

  function automatic int unsigned width_len();
    int unsigned l;
    int unsigned d;
    l = reg_len;
    d = width_dist();
    if (l < 1) l = 1;
    if (l > lzsd_pkg::MAX_LEN_BITS_DEF) l = lzsd_pkg::MAX_LEN_BITS_DEF;
    if (l >= d) l = d - 1;
    return l;
  endfunction

  function automatic int unsigned width_count();
    int unsigned c;
    c = reg_count;
    if (c < 1) c = 1;
    if (c > lzsd_pkg::LIT_BITS) c = lzsd_pkg::LIT_BITS;
    return c;
  endfunction

  function automatic int unsigned take_bits(input int unsigned n);
    int unsigned v;
    v = int'(acc & ((64'd1 << n) - 64'd1));
    acc = acc >> n;
    held = held - n;
    return v;
  endfunction

  function automatic void push_result(input logic [1:0] k, input logic [7:0] b);
    if (have_res) expected_q.insert(expected_q.size(), last_res);
    last_res.kind     = k;
    last_res.out_byte = b;
    last_res.run_last = 1'b0;
    have_res = 1'b1;
    step_n++;
  endfunction

  function automatic void record_byte(input logic [7:0] b);
    hist[wp] = b;
    wp = wp + 12'd1;
    if (fill < HIST_DEPTH) fill++;
  endfunction

  // expected results of one accepted compressed word
  function automatic void decode_word(input logic [7:0] w);
    int unsigned dw, lw, cw, v, back, win, lim, i;
    logic [7:0]  x;
    bit          more;
    if (halted) return;
    step_n   = 0;
    have_res = 1'b0;
    more     = 1'b1;
    if (held <= lzsd_pkg::ACC_LIMIT) begin
      acc  = acc | ({56'd0, w} << held);
      held = held + 8;
    end
    while (more) begin
      dw = width_dist();
      lw = width_len();
      cw = width_count();
      case (ph)
        lzsd_pkg::PH_LEN: begin
          if (held < lw) more = 1'b0;
          else begin
            v = take_bits(lw);
            if (v != 0) begin
              pend_len = v;
              ph = lzsd_pkg::PH_DIST;
            end else ph = lzsd_pkg::PH_COUNT;
          end
        end
        lzsd_pkg::PH_DIST: begin
          // a copy that would overflow this word's result budget waits for the next word
          if (held < dw || step_n + pend_len + 1 > lzsd_pkg::MAX_RESULTS) more = 1'b0;
          else begin
            back = take_bits(dw);
            win  = (1 << dw) - (1 << lw);
            lim  = (fill < win) ? fill : win;
            if (back == 0 || back > lim) begin
              push_result(lzsd_pkg::KIND_BAD_DIST, 8'd0);
              halted = 1'b1;
              more   = 1'b0;
            end else begin
              for (i = 0; i <= pend_len; i++) begin
                x = hist[wp - back[11:0]];
                push_result(lzsd_pkg::KIND_BYTE, x);
                record_byte(x);
              end
              ph = lzsd_pkg::PH_LEN;
            end
          end
        end
        lzsd_pkg::PH_COUNT: begin
          if (held < cw || step_n + 1 > lzsd_pkg::MAX_RESULTS) more = 1'b0;
          else begin
            v = take_bits(cw);
            if (v == 0) begin
              push_result(lzsd_pkg::KIND_END, 8'd0);
              halted = 1'b1;
              more   = 1'b0;
            end else begin
              lits_left = v;
              ph = lzsd_pkg::PH_LIT;
            end
          end
        end
        default: begin
          if (held < lzsd_pkg::LIT_BITS || step_n + 1 > lzsd_pkg::MAX_RESULTS) more = 1'b0;
          else begin
            x = 8'(take_bits(lzsd_pkg::LIT_BITS));
            push_result(lzsd_pkg::KIND_BYTE, x);
            record_byte(x);
            if (lits_left > 0) lits_left--;
            if (lits_left == 0) ph = lzsd_pkg::PH_LEN;
          end
        end
      endcase
    end
    if (have_res) begin
      last_res.run_last = 1'b1;
      expected_q.insert(expected_q.size(), last_res);
    end
  endfunction

  // ---------------- stream builder ----------------

  task automatic put_bits(input int unsigned v, input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      wbuf[wcnt] = v[i];
      wcnt++;
      if (wcnt == 8) begin
        word_q.insert(word_q.size(), wbuf);
        words_made++;
        wcnt = 0;
      end
    end
  endtask

  task automatic set_widths();
    gd      = width_dist();
    gl      = width_len();
    gc      = width_count();
    gen_win = (1 << gd) - (1 << gl);
  endtask

  task automatic put_copy(input int unsigned v, input int unsigned back);
    put_bits(v, gl);
    put_bits(back, gd);
    gen_out += v + 1;
  endtask

  task automatic add_token(input int unsigned copy_pct);
    int unsigned lim, cmax, cnt, v, back;
    lim = (gen_out < gen_win) ? gen_out : gen_win;
    if (lim == 0 || $urandom_range(0, 99) >= copy_pct) begin
      cmax = (1 << gc) - 1;
      cnt  = $urandom_range(1, (cmax > 8) ? 8 : cmax);
      put_bits(0, gl);
      put_bits(cnt, gc);
      repeat (cnt) put_bits($urandom_range(0, 255), lzsd_pkg::LIT_BITS);
      gen_out += cnt;
    end else begin
      v = ($urandom_range(0, 3) == 0) ? (1 << gl) - 1 : $urandom_range(1, (1 << gl) - 1);
      case ($urandom_range(0, 3))
        0:       back = 1;
        1:       back = lim;
        default: back = $urandom_range(1, lim);
      endcase
      put_copy(v, back);
    end
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || in_ch.valid || expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic bit parser_clean();
    return held == 0 && ph == lzsd_pkg::PH_LEN && !halted;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      lzsd_pkg::CFG_DIST:  reg_dist  = val;
      lzsd_pkg::CFG_LEN:   reg_len   = val[2:0];
      lzsd_pkg::CFG_COUNT: reg_count = val;
      default: ;
    endcase
  endtask

  // new widths only at a token boundary, otherwise the old ones stay
  task automatic apply_regs(input logic [3:0] d, input logic [3:0] l, input logic [3:0] c);
    if (parser_clean()) begin
      write_reg(lzsd_pkg::CFG_DIST, d);
      write_reg(lzsd_pkg::CFG_LEN, l);
      write_reg(lzsd_pkg::CFG_COUNT, c);
      @(posedge clk);
      cfg_we <= 1'b0;
      settings_used++;
    end
  endtask

  // random tokens up to a word count, ending on a word boundary, then drain
  task automatic fill_phase(input int unsigned nwords, input int unsigned copy_pct);
    int unsigned start, tries;
    calm  = ($urandom_range(0, 2) == 0);
    set_widths();
    start = words_made;
    while (words_made - start < nwords || wcnt != 0) add_token(copy_pct);
    wait_idle();
    tries = 0;
    while (!parser_clean() && !halted && tries < 4) begin
      do add_token(copy_pct); while (wcnt != 0);
      wait_idle();
      tries++;
    end
  endtask

  function automatic int unsigned pause_len();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // ---------------- clock, driver, monitor ----------------

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still expected", cycles, expected_q.size());
    $display("tb_lzss_bitstream_decoder: FAIL");
    $finish;
  end

  int unsigned in_gap;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.in_byte <= 8'd0;
      in_gap        <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_word(in_ch.in_byte);
        words_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap != 0) begin
          in_ch.valid <= 1'b0;
          in_gap      <= in_gap - 1;
        end else if (word_q.size() != 0) begin
          in_ch.valid   <= 1'b1;
          in_ch.in_byte <= word_q.pop_front();
          in_gap        <= pause_len();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  int unsigned    out_stall;
  int unsigned    next_stall;
  lzsd_pkg::res_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected word: kind=%0d out_byte=%02h run_last=%0b",
               out_ch.kind, out_ch.out_byte, out_ch.run_last);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          errors++;
        end
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_ch.out_byte);
          errors++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_ch.run_last);
          errors++;
        end
      end
      next_stall = pause_len();
      out_ch.ready <= (next_stall == 0);
      out_stall    <= next_stall;
    end else if (out_stall != 0) begin
      out_ch.ready <= (out_stall == 1);
      out_stall    <= out_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------- stimulus ----------------

  int unsigned lim;

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = lzsd_pkg::CFG_DIST;
    cfg_data      = 4'd0;
    acc = '0; held = 0; ph = lzsd_pkg::PH_LEN; pend_len = 0; lits_left = 0;
    wp = '0; fill = 0; halted = 1'b0;
    reg_dist  = lzsd_pkg::CFG_DIST_RST;
    reg_len   = lzsd_pkg::CFG_LEN_RST;
    reg_count = lzsd_pkg::CFG_COUNT_RST;
    wbuf = '0; wcnt = 0; words_made = 0; gen_out = 0;
    calm = 1'b0; errors = 0; words_in = 0; results_seen = 0; settings_used = 1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset widths: literal extremes, a longest self-overlapping copy, a copy from the
    // oldest byte held, then a short copy
    set_widths();
    put_bits(0, gl);
    put_bits(5, gc);
    put_bits(8'h00, lzsd_pkg::LIT_BITS);
    put_bits(8'h00, lzsd_pkg::LIT_BITS);
    put_bits(8'hFF, lzsd_pkg::LIT_BITS);
    put_bits(8'hFF, lzsd_pkg::LIT_BITS);
    put_bits(8'h5A, lzsd_pkg::LIT_BITS);
    gen_out += 5;
    put_copy((1 << gl) - 1, 1);
    put_copy(1, gen_out);
    put_copy(3, 2);
    fill_phase(12, 50);

    apply_regs(4'd2, 4'd1, 4'd1);     // narrowest fields, two byte window
    fill_phase(40, 50);
    apply_regs(4'd6, 4'd5, 4'd1);     // 11-bit copies of 32 bytes hit the result budget
    fill_phase(40, 85);
    apply_regs(4'd0, 4'd0, 4'd0);     // below range, clamps up
    fill_phase(30, 40);
    apply_regs(4'd15, 4'd7, 4'd15);   // above range, clamps down
    fill_phase(40, 50);
    apply_regs(4'd3, 4'd5, 4'd3);     // len width clamped below dist width
    fill_phase(40, 50);
    repeat (2) begin
      apply_regs(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 4'($urandom_range(0, 15)));
      fill_phase(40, 50);
    end

    // close the stream; the words after it must be dropped
    calm = 1'b0;
    set_widths();
    lim = (gen_out < gen_win) ? gen_out : gen_win;
    case ($urandom_range(0, 2))
      0: begin
        put_bits(0, gl);
        put_bits(0, gc);
        stop_note = "an end marker";
      end
      1: begin
        put_copy($urandom_range(1, (1 << gl) - 1), 0);
        stop_note = "a zero distance";
      end
      default: begin
        put_copy($urandom_range(1, (1 << gl) - 1), lim + 1);
        stop_note = "a distance past the history";
      end
    endcase
    if (wcnt != 0) put_bits($urandom_range(0, 255), 8 - wcnt);
    repeat (6) put_bits($urandom_range(0, 255), 8);
    wait_idle();

    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
    end
    $display("%0d compressed words in, %0d results checked, %0d register settings;",
             words_in, results_seen, settings_used);
    $display("stream closed by %s, %0d mismatches", stop_note, errors);
    if (errors == 0) begin
      $display("tb_lzss_bitstream_decoder: PASS");
    end else begin
      $display("tb_lzss_bitstream_decoder: FAIL");
    end
    $finish;
  end

endmodule
